### hw/rtl/mkt_pkg.sv
// ----------------------------------------------------------------------------
// mkt_pkg
// Shared types and constants for the markup tag tokenizer.
// ----------------------------------------------------------------------------
package mkt_pkg;

	localparam int MAX_RES = 4;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		MODE_TEXT  = 2'd0,
		MODE_TAG   = 2'd1,
		MODE_QUOTE = 2'd2
	} lex_mode_t;

	typedef struct packed {
		lex_mode_t mode;
		logic      token_open;
		logic      pend_open;
		logic      pend_close;
	} lex_state_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       tend;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [CNT_W-1:0]   cnt;
	} group_t;

endpackage

### hw/rtl/mkt_lexer.sv
// ----------------------------------------------------------------------------
// mkt_lexer
// Lexer state register and the per-word decode into a result group.
// ----------------------------------------------------------------------------
module mkt_lexer
	import mkt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] ch,
	output group_t     grp
);

	lex_state_t st_q;
	lex_state_t st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_TEXT, token_open: 1'b0, pend_open: 1'b0, pend_close: 1'b0};
		end else if (adv) begin
			st_q <= st_d;
		end
	end

	always_comb begin
		logic [CNT_W-1:0] n;
		logic             white;
		logic             quote;
		res_t             r [MAX_RES];
		logic             w [MAX_RES];
		n     = '0;
		white = (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);
		quote = (ch == CH_SQUOT) || (ch == CH_DQUOT);
		st_d  = st_q;
		for (int i = 0; i < MAX_RES; i++) begin
			r[i] = '{ch: CH_NUL, tend: 1'b0};
			w[i] = 1'b0;
		end
		// slot 0/1: pending angle, or token close at end of text
		if (ch == CH_NUL) begin
			if (st_q.token_open) begin
				r[0] = '{ch: CH_NUL, tend: 1'b1};
				n    = CNT_W'(1);
			end
			st_d = '{mode: MODE_TEXT, token_open: 1'b0, pend_open: 1'b0, pend_close: 1'b0};
		end else begin
			if (st_q.pend_open || st_q.pend_close) begin
				r[0] = '{ch: (st_q.pend_open ? CH_LT : CH_GT), tend: 1'b0};
				r[1] = '{ch: CH_NUL, tend: 1'b1};
				n    = CNT_W'(2);
				st_d.pend_open  = 1'b0;
				st_d.pend_close = st_q.pend_open ? st_q.pend_close : 1'b0;
			end
			unique case (st_q.mode)
				MODE_TAG: begin
					if (white) begin
						w[0] = st_q.token_open;
						st_d.token_open = 1'b0;
					end else if (quote) begin
						st_d.mode = MODE_QUOTE;
					end else if (ch == CH_GT) begin
						w[0] = st_q.token_open;
						st_d.token_open = 1'b0;
						st_d.mode = MODE_TEXT;
						st_d.pend_close = 1'b1;
					end else if (ch == CH_EQ) begin
						w[0] = st_q.token_open;
						w[1] = 1'b1;
						w[2] = 1'b1;
						st_d.token_open = 1'b0;
					end else if (ch == CH_SLASH && !st_q.token_open) begin
						w[1] = 1'b1;
						w[2] = 1'b1;
					end else begin
						w[1] = 1'b1;
						st_d.token_open = 1'b1;
					end
				end
				MODE_QUOTE: begin
					if (quote) begin
						w[0] = st_q.token_open;
						st_d.token_open = 1'b0;
						st_d.mode = MODE_TAG;
					end else begin
						w[1] = 1'b1;
						st_d.token_open = 1'b1;
					end
				end
				default: begin
					st_d.mode = MODE_TEXT;
					if (ch == CH_LT) begin
						w[0] = st_q.token_open;
						st_d.token_open = 1'b0;
						st_d.mode = MODE_TAG;
						st_d.pend_open = 1'b1;
					end else begin
						w[1] = 1'b1;
						st_d.token_open = 1'b1;
					end
				end
			endcase
			// w[0]: end marker, w[1]: the char, w[2]: end marker after the char
			for (int k = 0; k < 3; k++) begin
				if (w[k] && n < CNT_W'(MAX_RES)) begin
					r[n[IDX_W-1:0]] = (k == 1) ? '{ch: ch, tend: 1'b0}
					                           : '{ch: CH_NUL, tend: 1'b1};
					n = n + CNT_W'(1);
				end
			end
		end
		for (int i = 0; i < MAX_RES; i++) begin
			grp.res[i] = r[i];
		end
		grp.cnt = n;
	end

endmodule

### hw/rtl/mkt_emit.sv
// ----------------------------------------------------------------------------
// mkt_emit
// Result group register; hands out one result per output word.
// ----------------------------------------------------------------------------
module mkt_emit
	import mkt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  group_t     grp,
	output logic       free,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       token_end,
	output logic       last
);

	res_t             res_s2 [MAX_RES];
	logic [CNT_W-1:0] cnt_s2;
	logic [IDX_W-1:0] idx_q;
	logic             vld_s2;
	logic             fire;
	logic             done;

	assign fire      = vld_s2 && !out_stall;
	assign last      = ({1'b0, idx_q} == (cnt_s2 - CNT_W'(1)));
	assign done      = fire && last;
	assign free      = !vld_s2 || done;
	assign out_valid = vld_s2;
	assign out_char  = res_s2[idx_q].ch;
	assign token_end = res_s2[idx_q].tend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			vld_s2 <= (grp.cnt != '0);
			idx_q  <= '0;
		end else if (done) begin
			vld_s2 <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cnt_s2 <= grp.cnt;
			for (int i = 0; i < MAX_RES; i++) begin
				res_s2[i] <= grp.res[i];
			end
		end
	end

endmodule

### hw/rtl/markup_tag_tokenizer.sv
// ----------------------------------------------------------------------------
// markup_tag_tokenizer
// Splits a markup byte stream into token characters and token-end markers.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  input   | in_valid / in_stall  | in_char
//  output  | out_valid / out_stall| out_char, token_end, last
//
//  Input word registered in s1, decoded into up to four results held in s2.
//  The s2 result group gives one output word per cycle while out_stall is
//  low; the next input word moves from s1 to s2 once s2 is empty or its last
//  result is taken. From accept, a word passes the s1 and s2 registers in turn.
//  arst_n clears the lexer to text mode with no token open.
//  out_stall backs up into in_stall in the same cycle once s1 is occupied.
module markup_tag_tokenizer
	import mkt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       token_end,
	output logic       last
);

	logic [7:0] char_s1;
	logic       vld_s1;
	logic       free;
	logic       adv;
	group_t     grp;

	assign adv      = vld_s1 && free;
	assign in_stall = vld_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= in_char;
		end
	end

	mkt_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ch     (char_s1),
		.grp    (grp)
	);

	mkt_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.grp       (grp),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.token_end (token_end),
		.last      (last)
	);

endmodule

### hw/rtl/mkt_checker.sv
// ----------------------------------------------------------------------------
// mkt_checker
// Port-level checks on the tokenizer output stream.
// ----------------------------------------------------------------------------
module mkt_checker
	import mkt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_char,
	input logic       token_end,
	input logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(token_end)
			&& $stable(last))
		else $error("stalled output word changed");

	a_end_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_end |-> out_char == CH_NUL)
		else $error("token end carries a character");

	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !token_end |-> out_char != CH_NUL)
		else $error("zero byte emitted as token character");

	a_no_double_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && token_end |=> !(out_valid && token_end))
		else $error("empty token marked");

endmodule

bind markup_tag_tokenizer mkt_checker u_mkt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_char  (out_char),
	.token_end (token_end),
	.last      (last)
);
